/* design/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define TQS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define TQS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define TQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/tqs_pkg.sv */
package tqs_pkg;

	// field widths
	localparam int TIME_W = 48;
	localparam int ID_W = 32;
	localparam int TO_W = 32;

	// most fired timers reported per tick
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	// input word kinds
	typedef enum logic [1:0] {
		KIND_POST_ONCE   = 2'd0,
		KIND_POST_REPEAT = 2'd1,
		KIND_CANCEL      = 2'd2,
		KIND_TICK        = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_POSTED     = 3'd0,
		ST_QUEUE_FULL = 3'd1,
		ST_CANCEL_REC = 3'd2,
		ST_CANCEL_FULL = 3'd3,
		ST_FIRED      = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [TO_W-1:0] timeout;
		logic [ID_W-1:0] cancel_id;
	} req_word_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] timer_number;
		logic            last;
	} rsp_word_t;

	// one timer as held by a chain cell
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0]   id;
		logic [TO_W-1:0]   interval;
	} entry_t;

	// chain operations, applied to every cell at once
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2
	} chain_op_t;

	typedef struct packed {
		logic add;
		logic clr;
	} cset_ctl_t;

	typedef struct packed {
		logic hit;
		logic full;
	} cset_sts_t;

endpackage

/* design/tqs_if.sv */
// request channel
interface tqs_req_if;
	logic                  valid;
	logic                  ready;
	tqs_pkg::req_word_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// result channel
interface tqs_rsp_if;
	logic                  valid;
	logic                  ready;
	tqs_pkg::rsp_word_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/timer_queue_scheduler_top.sv */
// Timer queue: up to QUEUE_DEPTH timers kept sorted by deadline (ties to the lower id) in
// a chain of cells, plus a CANCEL_DEPTH cancel set. A post or a cancel gives one result
// word. A tick advances the clock, then takes expired timers off the head of the chain
// (fired, or silently dropped as cancelled; at most MAX_RESULTS fired per tick), re-arms
// each repeating timer that fired, and finally hands out the last result; the chain does
// at most one insert or one pop per cycle.
// A stalled result channel holds the scan.
`include "assert_macros.svh"

module timer_queue_scheduler_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int CANCEL_DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	tqs_req_if.sink   req,
	tqs_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_REINS = 3'b100
	} state_t;

	state_t                       state_q, state_d;
	logic [tqs_pkg::TIME_W-1:0]   cur_time_q;
	logic [tqs_pkg::ID_W-1:0]     next_id_q;
	logic [tqs_pkg::ID_W-1:0]     new_id;
	logic                         rsp_v_q;
	tqs_pkg::rsp_word_t           rsp_d_q, rsp_load_d;
	logic                         rsp_load;
	logic                         out_free;
	logic                         pend_q, pend_d;
	logic [tqs_pkg::ID_W-1:0]     pend_id_q, pend_id_d;
	logic [tqs_pkg::CNT_W-1:0]    n_q, n_d;
	tqs_pkg::entry_t              hold_q, hold_d;
	tqs_pkg::chain_op_t           chain_op;
	tqs_pkg::entry_t              chain_new;
	tqs_pkg::entry_t              cell_e [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]       ahead;
	logic [QUEUE_DEPTH-1:0]       vld;
	tqs_pkg::entry_t              head;
	logic                         q_full;
	logic                         expired;
	logic                         accept;
	logic                         is_post;
	logic [tqs_pkg::ID_W-1:0]     cs_key;
	tqs_pkg::cset_ctl_t           cs_ctl;
	tqs_pkg::cset_sts_t           cs_sts;

	// chain of sorted cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		tqs_pkg::entry_t left_e, right_e;
		logic            left_b;
		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_b = 1'b1;
		end else begin : g_mid
			assign left_e = cell_e[i-1];
			assign left_b = ahead[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cell_e[i+1];
		end
		tqs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (chain_op),
			.new_entry  (chain_new),
			.left       (left_e),
			.right      (right_e),
			.left_ahead (left_b),
			.entry      (cell_e[i]),
			.ahead      (ahead[i])
		);
		assign vld[i] = cell_e[i].valid;
	end

	assign head = cell_e[0];
	assign q_full = vld[QUEUE_DEPTH-1];
	assign expired = head.valid && (head.deadline <= cur_time_q);

	// cancel set, looked up by the head id while scanning
	assign cs_key = (state_q == S_SCAN) ? head.id : req.data.cancel_id;

	tqs_cancel_set #(.CANCEL_DEPTH(CANCEL_DEPTH)) u_cset (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (cs_key),
		.ctl    (cs_ctl),
		.sts    (cs_sts)
	);

	// handshake
	assign out_free = !rsp_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept = req.valid && req.ready;
	assign rsp.valid = rsp_v_q;
	assign rsp.data = rsp_d_q;
	assign new_id = next_id_q + 1'b1;
	assign is_post = (req.data.kind == tqs_pkg::KIND_POST_ONCE) ||
		(req.data.kind == tqs_pkg::KIND_POST_REPEAT);

	// sequencer
	always_comb begin
		state_d = state_q;
		chain_op = tqs_pkg::OP_HOLD;
		chain_new = '0;
		cs_ctl = '0;
		rsp_load = 1'b0;
		rsp_load_d = '0;
		pend_d = pend_q;
		pend_id_d = pend_id_q;
		n_d = n_q;
		hold_d = hold_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.data.kind)
						tqs_pkg::KIND_POST_ONCE, tqs_pkg::KIND_POST_REPEAT: begin
							rsp_load = 1'b1;
							rsp_load_d.timer_number = new_id;
							rsp_load_d.last = 1'b1;
							if (q_full) begin
								rsp_load_d.status = tqs_pkg::ST_QUEUE_FULL;
							end else begin
								rsp_load_d.status = tqs_pkg::ST_POSTED;
								chain_op = tqs_pkg::OP_INSERT;
								chain_new.valid = 1'b1;
								chain_new.deadline = cur_time_q +
									{{(tqs_pkg::TIME_W-tqs_pkg::TO_W){1'b0}}, req.data.timeout};
								chain_new.id = new_id;
								chain_new.interval =
									(req.data.kind == tqs_pkg::KIND_POST_REPEAT) ?
									req.data.timeout : '0;
							end
						end
						tqs_pkg::KIND_CANCEL: begin
							rsp_load = 1'b1;
							rsp_load_d.timer_number = req.data.cancel_id;
							rsp_load_d.last = 1'b1;
							if (!cs_sts.hit && cs_sts.full) begin
								rsp_load_d.status = tqs_pkg::ST_CANCEL_FULL;
							end else begin
								rsp_load_d.status = tqs_pkg::ST_CANCEL_REC;
								cs_ctl.add = !cs_sts.hit;
							end
						end
						default: begin
							n_d = '0;
							pend_d = 1'b0;
							state_d = S_SCAN;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (expired && n_q < tqs_pkg::CNT_W'(tqs_pkg::MAX_RESULTS)) begin
					if (cs_sts.hit) begin
						// cancelled: drop silently
						cs_ctl.clr = 1'b1;
						chain_op = tqs_pkg::OP_POP;
					end else if (!pend_q || out_free) begin
						if (pend_q) begin
							rsp_load = 1'b1;
							rsp_load_d.status = tqs_pkg::ST_FIRED;
							rsp_load_d.timer_number = pend_id_q;
							rsp_load_d.last = 1'b0;
						end
						pend_d = 1'b1;
						pend_id_d = head.id;
						n_d = n_q + 1'b1;
						chain_op = tqs_pkg::OP_POP;
						if (head.interval != '0) begin
							hold_d.valid = 1'b1;
							hold_d.deadline = cur_time_q +
								{{(tqs_pkg::TIME_W-tqs_pkg::TO_W){1'b0}}, head.interval};
							hold_d.id = head.id;
							hold_d.interval = head.interval;
							state_d = S_REINS;
						end
					end
				end else if (!pend_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					rsp_load = 1'b1;
					rsp_load_d.status = tqs_pkg::ST_FIRED;
					rsp_load_d.timer_number = pend_id_q;
					rsp_load_d.last = 1'b1;
					pend_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_REINS: begin
				// re-arm a repeating timer
				chain_op = tqs_pkg::OP_INSERT;
				chain_new = hold_q;
				state_d = S_SCAN;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_time_q <= '0;
			next_id_q <= '0;
			rsp_v_q <= 1'b0;
			pend_q <= 1'b0;
			n_q <= '0;
		end else begin
			state_q <= state_d;
			pend_q <= pend_d;
			n_q <= n_d;
			if (accept && is_post)
				next_id_q <= new_id;
			if (accept && req.data.kind == tqs_pkg::KIND_TICK)
				cur_time_q <= cur_time_q + 1'b1;
			if (rsp_load)
				rsp_v_q <= 1'b1;
			else if (rsp.ready)
				rsp_v_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rsp_load)
			rsp_d_q <= rsp_load_d;
		pend_id_q <= pend_id_d;
		hold_q <= hold_d;
	end

	// chain stays packed toward the head
	`TQS_ASSERT_ALWAYS(a_chain_packed, clk, arst_n, (vld & (vld + 1'b1)) == '0)
	// a stored post adds exactly one timer
	`TQS_ASSERT_NEXT(a_post_grows, clk, arst_n, accept && is_post && !q_full, $countones(vld) == $past($countones(vld)) + 1)
	// never more fired results per tick than the limit
	`TQS_ASSERT_ALWAYS(a_fire_limit, clk, arst_n, n_q <= tqs_pkg::CNT_W'(tqs_pkg::MAX_RESULTS))
	// a new result is loaded only when the output register is free
	`TQS_ASSERT_IMPL(a_no_overrun, clk, arst_n, rsp_load, out_free)

endmodule

/* design/tqs_cell.sv */
module tqs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tqs_pkg::chain_op_t  op,
	input  tqs_pkg::entry_t     new_entry,
	input  tqs_pkg::entry_t     left,
	input  tqs_pkg::entry_t     right,
	input  logic                left_ahead,
	output tqs_pkg::entry_t     entry,
	output logic                ahead
);

	logic                      valid_q;
	logic [tqs_pkg::TIME_W-1:0] deadline_q;
	logic [tqs_pkg::ID_W-1:0]   id_q;
	logic [tqs_pkg::TO_W-1:0]   interval_q;
	tqs_pkg::entry_t           nxt;

	assign entry = '{valid: valid_q, deadline: deadline_q, id: id_q, interval: interval_q};

	// this cell stays ahead of the new timer
	assign ahead = valid_q && (!new_entry.valid || deadline_q < new_entry.deadline ||
		(deadline_q == new_entry.deadline && id_q < new_entry.id));

	// next content from self, new timer or a neighbor
	always_comb begin
		nxt = entry;
		case (op)
			tqs_pkg::OP_INSERT: begin
				if (ahead)
					nxt = entry;
				else if (left_ahead)
					nxt = new_entry;
				else
					nxt = left;
			end
			tqs_pkg::OP_POP: nxt = right;
			default: nxt = entry;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= nxt.valid;
	end

	always_ff @(posedge clk) begin
		deadline_q <= nxt.deadline;
		id_q <= nxt.id;
		interval_q <= nxt.interval;
	end

endmodule

/* design/tqs_cancel_set.sv */
module tqs_cancel_set #(
	parameter int CANCEL_DEPTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [tqs_pkg::ID_W-1:0] key,
	input  tqs_pkg::cset_ctl_t      ctl,
	output tqs_pkg::cset_sts_t      sts
);

	logic [CANCEL_DEPTH-1:0]    vld_q;
	logic [tqs_pkg::ID_W-1:0]   id_q [CANCEL_DEPTH];
	logic [CANCEL_DEPTH-1:0]    match;
	logic [CANCEL_DEPTH-1:0]    first_free;

	// parallel compare of all entries
	always_comb begin
		for (int i = 0; i < CANCEL_DEPTH; i++)
			match[i] = vld_q[i] && (id_q[i] == key);
	end

	// lowest free entry, one-hot
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < CANCEL_DEPTH; i++) begin
			first_free[i] = !vld_q[i] && !seen;
			seen = seen || !vld_q[i];
		end
	end

	assign sts.hit = |match;
	assign sts.full = &vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (ctl.clr)
			vld_q <= vld_q & ~match;
		else if (ctl.add)
			vld_q <= vld_q | first_free;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CANCEL_DEPTH; i++)
			if (ctl.add && first_free[i])
				id_q[i] <= key;
	end

endmodule
